[design/cmap4_pkg.sv]
// ----------------------------------------------------------------------------
// cmap4_pkg
// Shared types and constants of the cmap format 4 glyph lookup block.
// ----------------------------------------------------------------------------
package cmap4_pkg;

	localparam int MAX_SEGMENTS_DEF = 256;
	localparam int GLYPH_WORDS_DEF  = 4096;

	localparam int CODE_W        = 16;
	localparam int SLOT_W        = 12;
	localparam int FUNC_W        = 2;
	localparam int STATUS_W      = 3;
	localparam int SEG_COUNT_W   = 9;
	localparam int GLYPH_COUNT_W = 13;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 13;
	// code - start + offset/2 - (nseg - seg) spans -256 .. 98301
	localparam int IDX_W         = 18;

	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_COUNT    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WORD_COUNT = 1'd1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD_SEG   = 2'd0,
		FUNC_LOAD_GLYPH = 2'd1,
		FUNC_LOOKUP     = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_MAPPED       = 3'd0,
		STAT_PAST_END     = 3'd1,
		STAT_BELOW_START  = 3'd2,
		STAT_GLYPH_ZERO   = 3'd3,
		STAT_OUT_OF_RANGE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CALC,
		S_INDEX,
		S_GREAD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0] end_code;
		logic [CODE_W-1:0] start_code;
		logic [CODE_W-1:0] delta;
		logic [CODE_W-1:0] range_offset;
	} seg_entry_t;

	typedef struct packed {
		logic [CODE_W-1:0] glyph_id;
		status_t           status;
	} result_t;

endpackage

[design/cmap4_char_to_glyph_lookup.sv]
// ----------------------------------------------------------------------------
// cmap4_char_to_glyph_lookup
// Maps a 16-bit character code to a glyph id with a cmap format 4 table.
//
// Load items (segment or glyph array word) are taken while no lookup is in
// progress and give no result. A lookup reads the segment memory one entry per
// cycle until the first segment whose end code is not below the code, then steps
// through the start check, the index arithmetic, the glyph array read and the
// result hand-off; a code below the start, a zero range offset or an index out
// of range goes straight to the hand-off, as does a scan that runs past all
// segments. The scan is bound by the single read port of the segment
// memory. A result that cannot enter the output register holds the
// input for as long as it waits. Items are worked one at a time; a finished
// result waits in the output register while the next item is taken. The
// memories need no clearing after reset; entries must be loaded before a
// lookup reaches them.
// ----------------------------------------------------------------------------
module cmap4_char_to_glyph_lookup #(
	parameter int MAX_SEGMENTS = cmap4_pkg::MAX_SEGMENTS_DEF,
	parameter int GLYPH_WORDS  = cmap4_pkg::GLYPH_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cmap4_pkg::FUNC_W-1:0]        func,
	input  logic [cmap4_pkg::SLOT_W-1:0]        slot,
	input  logic [cmap4_pkg::CODE_W-1:0]        end_code,
	input  logic [cmap4_pkg::CODE_W-1:0]        start_code,
	input  logic signed [cmap4_pkg::CODE_W-1:0] delta,
	input  logic [cmap4_pkg::CODE_W-1:0]        range_offset,
	input  logic [cmap4_pkg::CODE_W-1:0]        glyph_word,
	input  logic [cmap4_pkg::CODE_W-1:0]        char_code,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cmap4_pkg::CODE_W-1:0]        glyph_id,
	output logic [cmap4_pkg::STATUS_W-1:0]      status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cmap4_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cmap4_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import cmap4_pkg::*;

	logic [SEG_COUNT_W-1:0]   seg_count_q;
	logic [GLYPH_COUNT_W-1:0] glyph_count_q;
	logic                     take;
	logic                     busy;
	logic                     res_valid, res_ready;
	result_t                  res;
	seg_entry_t               seg_wdata;
	logic                     out_valid_q;
	result_t                  out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q   <= '0;
			glyph_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SEGMENT_COUNT:    seg_count_q   <= cfg_data[SEG_COUNT_W-1:0];
				REG_GLYPH_WORD_COUNT: glyph_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = busy;
	assign take     = in_valid && !in_stall;

	assign seg_wdata = '{end_code: end_code, start_code: start_code,
	                     delta: $unsigned(delta), range_offset: range_offset};

	cmap4_engine #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.GLYPH_WORDS  (GLYPH_WORDS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.func        (func),
		.slot        (slot),
		.seg_wdata   (seg_wdata),
		.glyph_word  (glyph_word),
		.char_code   (char_code),
		.seg_count   (seg_count_q),
		.glyph_count (glyph_count_q),
		.busy        (busy),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register: refill as the held result drains
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign glyph_id  = out_q.glyph_id;
	assign status    = out_q.status;

	// a lookup transfer always keeps the engine busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (func == FUNC_LOOKUP)) |=> in_stall)
		else $error("lookup accepted but engine not busy");

	// no new item while a result is still leaving the engine
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_stall)
		else $error("input taken while result pending");

	// a result handed to the output register shows up on the port
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid)
		else $error("result transfer lost");

	// every miss status carries glyph 0
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_MAPPED)) |-> (glyph_id == '0))
		else $error("nonzero glyph on a miss");

endmodule

[design/cmap4_ram.sv]
// ----------------------------------------------------------------------------
// cmap4_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cmap4_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read word while re is low
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/cmap4_engine.sv]
// ----------------------------------------------------------------------------
// cmap4_engine
// Segment and glyph array memories with the load, scan and map sequencer.
// ----------------------------------------------------------------------------
module cmap4_engine #(
	parameter int MAX_SEGMENTS = cmap4_pkg::MAX_SEGMENTS_DEF,
	parameter int GLYPH_WORDS  = cmap4_pkg::GLYPH_WORDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic [cmap4_pkg::FUNC_W-1:0]          func,
	input  logic [cmap4_pkg::SLOT_W-1:0]          slot,
	input  cmap4_pkg::seg_entry_t                 seg_wdata,
	input  logic [cmap4_pkg::CODE_W-1:0]          glyph_word,
	input  logic [cmap4_pkg::CODE_W-1:0]          char_code,
	input  logic [cmap4_pkg::SEG_COUNT_W-1:0]     seg_count,
	input  logic [cmap4_pkg::GLYPH_COUNT_W-1:0]   glyph_count,
	output logic                                  busy,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output cmap4_pkg::result_t                    res
);
	import cmap4_pkg::*;

	localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
	localparam int GL_AW  = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
	localparam int GL_CW  = $clog2(GLYPH_WORDS + 1);

	state_t state_q, state_d;

	logic [31:0]       slot_w;
	logic              seg_we, glyph_we;
	logic              seg_re, glyph_re;
	logic [SEG_CW-1:0] nseg_d;
	logic [GL_CW-1:0]  nwords_d;
	logic              lookup;

	seg_entry_t        seg_rd;
	logic [SEG_AW-1:0] seg_raddr;
	logic [GL_AW-1:0]  glyph_raddr;
	logic [CODE_W-1:0] glyph_rd;

	logic [SEG_CW-1:0] issue_q, chk_q, seg_q, nseg_q;
	logic              dval_q;
	logic              hit;
	logic [GL_CW-1:0]  nwords_q;
	logic [CODE_W-1:0] code_q, start_q, delta_q, range_q;
	logic [CODE_W:0]   diff;
	logic              below;
	logic [IDX_W-1:0]  idx_calc, idx_q;
	logic              oor;
	result_t           res_q;

	assign slot_w   = 32'(slot);
	assign seg_we   = take && (func == FUNC_LOAD_SEG) && (slot_w < 32'(MAX_SEGMENTS));
	assign glyph_we = take && (func == FUNC_LOAD_GLYPH) && (slot_w < 32'(GLYPH_WORDS));
	assign lookup   = take && (func == FUNC_LOOKUP);

	assign nseg_d   = (32'(seg_count) > 32'(MAX_SEGMENTS)) ? SEG_CW'(MAX_SEGMENTS)
	                                                       : SEG_CW'(seg_count);
	assign nwords_d = (32'(glyph_count) > 32'(GLYPH_WORDS)) ? GL_CW'(GLYPH_WORDS)
	                                                        : GL_CW'(glyph_count);

	cmap4_ram #(
		.WIDTH ($bits(seg_entry_t)),
		.DEPTH (MAX_SEGMENTS)
	) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (slot_w[SEG_AW-1:0]),
		.wdata (seg_wdata),
		.re    (seg_re),
		.raddr (seg_raddr),
		.rdata (seg_rd)
	);

	cmap4_ram #(
		.WIDTH (CODE_W),
		.DEPTH (GLYPH_WORDS)
	) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (slot_w[GL_AW-1:0]),
		.wdata (glyph_word),
		.re    (glyph_re),
		.raddr (glyph_raddr),
		.rdata (glyph_rd)
	);

	// scan: read one segment per cycle, compare each registered read word as it returns
	assign hit       = dval_q && (code_q <= seg_rd.end_code);
	assign seg_re    = (state_q == S_SCAN) && !hit && (issue_q < nseg_q);
	assign seg_raddr = issue_q[SEG_AW-1:0];

	assign diff     = {1'b0, code_q} - {1'b0, start_q};
	assign below    = diff[CODE_W];
	assign idx_calc = IDX_W'(diff[CODE_W-1:0]) + IDX_W'(range_q[CODE_W-1:1])
	                  - IDX_W'(nseg_q) + IDX_W'(seg_q);

	assign oor         = idx_q[IDX_W-1] || (idx_q[IDX_W-2:0] >= (IDX_W-1)'(nwords_q));
	assign glyph_re    = (state_q == S_INDEX) && !oor;
	assign glyph_raddr = idx_q[GL_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= '0;
			dval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			dval_q  <= seg_re;
			if (state_q == S_IDLE) begin
				issue_q <= '0;
			end else if (seg_re) begin
				issue_q <= issue_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (lookup) begin
					state_d = (nseg_d == '0) ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_CALC;
				end else if (dval_q && (issue_q == nseg_q)) begin
					state_d = S_DONE;
				end
			end
			S_CALC: begin
				state_d = (below || (range_q == '0)) ? S_DONE : S_INDEX;
			end
			S_INDEX: begin
				state_d = oor ? S_DONE : S_GREAD;
			end
			S_GREAD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (seg_re) begin
			chk_q <= issue_q;
		end
		case (state_q)
			S_IDLE: begin
				if (lookup) begin
					code_q   <= char_code;
					nseg_q   <= nseg_d;
					nwords_q <= nwords_d;
					// default answer when the scan runs off the end
					res_q    <= '{glyph_id: '0, status: STAT_PAST_END};
				end
			end
			S_SCAN: begin
				if (hit) begin
					start_q <= seg_rd.start_code;
					delta_q <= seg_rd.delta;
					range_q <= seg_rd.range_offset;
					seg_q   <= chk_q;
				end
			end
			S_CALC: begin
				if (below) begin
					res_q <= '{glyph_id: '0, status: STAT_BELOW_START};
				end else if (range_q == '0) begin
					res_q <= '{glyph_id: code_q + delta_q, status: STAT_MAPPED};
				end
				idx_q <= idx_calc;
			end
			S_INDEX: begin
				if (oor) begin
					res_q <= '{glyph_id: '0, status: STAT_OUT_OF_RANGE};
				end
			end
			S_GREAD: begin
				if (glyph_rd == '0) begin
					res_q <= '{glyph_id: '0, status: STAT_GLYPH_ZERO};
				end else begin
					res_q <= '{glyph_id: glyph_rd + delta_q, status: STAT_MAPPED};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the cmap format 4 character to glyph lookup.
//
// Segment tables and glyph arrays are loaded through the item port, then
// lookups are checked field by field against a table walk kept in this bench.
// Directed corner cases come first, then random well-formed tables of many
// sizes with noise loads. Sender bursts, receiver stalls, a long output
// hold-off and a full drain pause run along the way.
// ----------------------------------------------------------------------------
module tb;
	import cmap4_pkg::*;

	localparam int CLK_HALF         = 6;
	localparam int SEGS             = MAX_SEGMENTS_DEF;
	localparam int WORDS            = GLYPH_WORDS_DEF;
	localparam int SETTLE_CYCLES    = SEGS + 16;
	localparam int LONG_HOLD_CYCLES = 700;
	localparam int CYCLE_LIMIT      = 4_000_000;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef enum int {RX_FLOW, RX_RANDOM, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	typedef struct {
		logic [FUNC_W-1:0] fn;
		logic [SLOT_W-1:0] slot;
		seg_entry_t        seg;
		logic [CODE_W-1:0] word;
		logic [CODE_W-1:0] code;
	} cmap_item_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [FUNC_W-1:0]          func;
	logic [SLOT_W-1:0]          slot;
	logic [CODE_W-1:0]          end_code;
	logic [CODE_W-1:0]          start_code;
	logic signed [CODE_W-1:0]   delta;
	logic [CODE_W-1:0]          range_offset;
	logic [CODE_W-1:0]          glyph_word;
	logic [CODE_W-1:0]          char_code;
	logic                       out_valid;
	logic                       out_stall;
	logic [CODE_W-1:0]          glyph_id;
	logic [STATUS_W-1:0]        status;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	// table image as the block should hold it
	seg_entry_t        seg_table [SEGS];
	bit                seg_loaded [SEGS];
	logic [CODE_W-1:0] glyph_table [WORDS];
	bit                glyph_loaded [WORDS];
	int unsigned       seg_count_reg;
	int unsigned       word_count_reg;
	result_t           glyphs_due [$];

	int  lookups_done;
	int  loads_done;
	int  ignored_done;
	int  status_seen [5];
	int  mismatches;
	int  cycle_count;
	int  burst_left;
	bit  pacing_on;
	bit  long_hold_req;

	cmap4_char_to_glyph_lookup dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.slot        (slot),
		.end_code    (end_code),
		.start_code  (start_code),
		.delta       (delta),
		.range_offset(range_offset),
		.glyph_word  (glyph_word),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.glyph_id    (glyph_id),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic int segs_in_use();
		return (seg_count_reg > SEGS) ? SEGS : int'(seg_count_reg);
	endfunction

	// Walk the table for one code. Returns 0 when the walk would touch an
	// entry that was never loaded; such a lookup is never sent.
	function automatic bit trace_lookup(input logic [CODE_W-1:0] code, output result_t res);
		int nseg, nwords, s, idx;
		seg_entry_t e;
		nseg = segs_in_use();
		nwords = (word_count_reg > WORDS) ? WORDS : int'(word_count_reg);
		res.glyph_id = '0;
		res.status = STAT_MAPPED;
		for (s = 0; s < nseg; s++) begin
			if (!seg_loaded[s])
				return 1'b0;
			if (code <= seg_table[s].end_code)
				break;
		end
		if (s == nseg) begin
			res.status = STAT_PAST_END;
			return 1'b1;
		end
		e = seg_table[s];
		if (code < e.start_code) begin
			res.status = STAT_BELOW_START;
			return 1'b1;
		end
		if (e.range_offset == '0) begin
			res.glyph_id = code + e.delta;
			return 1'b1;
		end
		idx = int'(code) - int'(e.start_code) + int'(e.range_offset >> 1) - (nseg - s);
		if (idx < 0 || idx >= nwords) begin
			res.status = STAT_OUT_OF_RANGE;
			return 1'b1;
		end
		if (!glyph_loaded[idx])
			return 1'b0;
		if (glyph_table[idx] == '0) begin
			res.status = STAT_GLYPH_ZERO;
			return 1'b1;
		end
		res.glyph_id = glyph_table[idx] + e.delta;
		return 1'b1;
	endfunction

	function automatic cmap_item_t lookup_item(input logic [CODE_W-1:0] code);
		cmap_item_t it;
		it.fn = FUNC_LOOKUP;
		it.slot = SLOT_W'($urandom);
		it.seg = {$urandom, $urandom};
		it.word = CODE_W'($urandom);
		it.code = code;
		return it;
	endfunction

	function automatic cmap_item_t seg_item(input int s, input logic [CODE_W-1:0] last,
			input logic [CODE_W-1:0] first, input logic [CODE_W-1:0] id_delta,
			input logic [CODE_W-1:0] offset);
		cmap_item_t it;
		it = lookup_item(CODE_W'($urandom));
		it.fn = FUNC_LOAD_SEG;
		it.slot = SLOT_W'(s);
		it.seg.end_code = last;
		it.seg.start_code = first;
		it.seg.delta = id_delta;
		it.seg.range_offset = offset;
		return it;
	endfunction

	function automatic cmap_item_t glyph_item(input int s, input logic [CODE_W-1:0] w);
		cmap_item_t it;
		it = lookup_item(CODE_W'($urandom));
		it.fn = FUNC_LOAD_GLYPH;
		it.slot = SLOT_W'(s);
		it.word = w;
		return it;
	endfunction

	function automatic logic [CODE_W-1:0] glyph_value();
		return ($urandom_range(0, 7) == 0) ? '0 : CODE_W'($urandom);
	endfunction

	// Offer one item, wait for its transfer, update the table image, then
	// maybe close the burst with a gap.
	task automatic send_item(input cmap_item_t it);
		result_t res;
		int gap;
		in_valid <= 1'b1;
		func <= it.fn;
		slot <= it.slot;
		end_code <= it.seg.end_code;
		start_code <= it.seg.start_code;
		delta <= it.seg.delta;
		range_offset <= it.seg.range_offset;
		glyph_word <= it.word;
		char_code <= it.code;
		do @(posedge clk); while (in_stall);
		case (it.fn)
			FUNC_LOAD_SEG: begin
				if (it.slot < SEGS) begin
					seg_table[it.slot] = it.seg;
					seg_loaded[it.slot] = 1'b1;
					loads_done++;
				end else begin
					ignored_done++;
				end
			end
			FUNC_LOAD_GLYPH: begin
				if (it.slot < WORDS) begin
					glyph_table[it.slot] = it.word;
					glyph_loaded[it.slot] = 1'b1;
					loads_done++;
				end else begin
					ignored_done++;
				end
			end
			FUNC_LOOKUP: begin
				void'(trace_lookup(it.code, res));
				glyphs_due.push_back(res);
				status_seen[int'(res.status)]++;
				lookups_done++;
			end
			default: ignored_done++;
		endcase
		if (pacing_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 12);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (glyphs_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write both size registers back to back; call only while drained.
	task automatic set_sizes(input int unsigned nseg, input int unsigned nwords);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SEGMENT_COUNT;
		cfg_data <= CFG_DATA_W'(nseg);
		do @(posedge clk); while (!cfg_ready);
		seg_count_reg = nseg % 512;
		cfg_index <= REG_GLYPH_WORD_COUNT;
		cfg_data <= CFG_DATA_W'(nwords);
		do @(posedge clk); while (!cfg_ready);
		word_count_reg = nwords % 8192;
		cfg_valid <= 1'b0;
	endtask

	// Build a sorted segment table of nseg entries; about half the segments
	// map through their own slice of the glyph array.
	task automatic load_font(input int nseg, output int words_used);
		int s, k, len, first, last, spacing;
		bit via_array;
		logic [CODE_W-1:0] offset;
		last = -1;
		words_used = 0;
		spacing = 60000 / nseg;
		for (s = 0; s < nseg; s++) begin
			first = last + 1 + $urandom_range(0, spacing / 4);
			via_array = 1'($urandom_range(0, 1));
			len = via_array ? $urandom_range(0, 3) : $urandom_range(0, spacing / 2);
			if (words_used + len + 1 > WORDS)
				via_array = 1'b0;
			last = (s == nseg - 1 && $urandom_range(0, 1) == 1) ? 16'hFFFF : first + len;
			offset = via_array ? CODE_W'(2 * (nseg - s + words_used) + $urandom_range(0, 1)) : '0;
			send_item(seg_item(s, CODE_W'(last), CODE_W'(first), CODE_W'($urandom), offset));
			if (via_array) begin
				for (k = 0; k <= len; k++)
					send_item(glyph_item(words_used + k, glyph_value()));
				words_used += len + 1;
			end
		end
	endtask

	// Mostly lookups aimed at loaded segments, plus noise loads and unused
	// codes. Lookups that would touch unloaded entries are redrawn.
	task automatic run_traffic(input int count);
		cmap_item_t it;
		result_t res;
		seg_entry_t e;
		int taken, attempts, tries, pick, nseg;
		bit safe;
		taken = 0;
		for (attempts = 0; taken < count && attempts < 4 * count; attempts++) begin
			nseg = segs_in_use();
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				it = glyph_item($urandom_range(0, WORDS - 1), glyph_value());
			end else if (pick < 9) begin
				it = seg_item($urandom_range(SEGS, (1 << SLOT_W) - 1), CODE_W'($urandom),
					CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
			end else if (pick < 11) begin
				it = seg_item($urandom_range(0, SEGS - 1), CODE_W'($urandom), CODE_W'($urandom),
					CODE_W'($urandom), CODE_W'($urandom));
			end else if (pick < 15) begin
				it = lookup_item(CODE_W'($urandom));
				it.fn = FUNC_UNUSED;
			end else begin
				safe = 1'b0;
				for (tries = 0; tries < 8 && !safe; tries++) begin
					it = lookup_item(CODE_W'($urandom));
					if (nseg > 0 && $urandom_range(0, 99) < 85) begin
						e = seg_table[$urandom_range(0, nseg - 1)];
						case ($urandom_range(0, 9))
							0: it.code = e.start_code - 1'b1;
							1: it.code = e.end_code + 1'b1;
							2: it.code = e.start_code;
							3: it.code = e.end_code;
							default: begin
								if (e.start_code <= e.end_code)
									it.code = CODE_W'($urandom_range(e.start_code,
										e.end_code));
							end
						endcase
					end
					safe = trace_lookup(it.code, res);
				end
				if (!safe)
					continue;
			end
			send_item(it);
			if (!(it.fn == FUNC_UNUSED || (it.fn == FUNC_LOAD_SEG && it.slot >= SEGS)))
				taken++;
		end
	endtask

	task automatic test_directed();
		logic [CODE_W-1:0] probe_codes [11] = '{16'h0020, 16'h0010, 16'h0040, 16'h0080,
			16'h0081, 16'h0082, 16'h0083, 16'h7000, 16'hFFFF, 16'h0000, 16'h9000};
		cmap_item_t it;
		pacing_on = 1'b0;
		set_sizes(0, 0);
		// empty table: every code runs past the end
		send_item(lookup_item(16'h1234));
		send_item(seg_item(0, 16'h0040, 16'h0020, 16'hFFE0, 16'h0000));
		send_item(seg_item(1, 16'h0100, 16'h0080, 16'h0010, 16'h0006));
		send_item(seg_item(2, 16'h8000, 16'h7000, 16'h8000, 16'h0002));
		send_item(seg_item(3, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000));
		// slot beyond the segment store: dropped
		send_item(seg_item((1 << SLOT_W) - 1, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000));
		send_item(glyph_item(0, 16'h1234));
		send_item(glyph_item(1, 16'h0000));
		send_item(glyph_item(2, 16'hFFFF));
		it = lookup_item(16'h0080);
		it.fn = FUNC_UNUSED;
		send_item(it);
		drain(SETTLE_CYCLES);
		set_sizes(4, 3);
		foreach (probe_codes[i])
			send_item(lookup_item(probe_codes[i]));
		drain(SETTLE_CYCLES);
		set_sizes(3, 3);
		send_item(lookup_item(16'h9000));
	endtask

	task automatic test_random_tables();
		int sizes [9] = '{1, 2, 3, 5, 8, 13, 20, 33, 64};
		int used, words;
		foreach (sizes[i]) begin
			pacing_on = (i % 3 != 2);
			drain(SETTLE_CYCLES);
			load_font(sizes[i], used);
			drain(SETTLE_CYCLES);
			case ($urandom_range(0, 3))
				0: words = 8191;
				1: words = (used > 3) ? used - $urandom_range(1, 3) : used;
				default: words = used;
			endcase
			set_sizes(sizes[i], words);
			run_traffic(30);
		end
	endtask

	task automatic test_size_extremes();
		int used;
		pacing_on = 1'b1;
		drain(SETTLE_CYCLES);
		load_font(SEGS, used);
		drain(SETTLE_CYCLES);
		// both counts above their stores: saturate
		set_sizes(511, 8191);
		run_traffic(20);
		drain(SETTLE_CYCLES);
		set_sizes(SEGS, WORDS);
		run_traffic(20);
		drain(SETTLE_CYCLES);
		set_sizes(SEGS, 0);
		run_traffic(15);
	endtask

	task automatic test_output_hold();
		drain(SETTLE_CYCLES);
		set_sizes(SEGS, WORDS);
		pacing_on = 1'b0;
		long_hold_req = 1'b1;
		run_traffic(24);
	endtask

	task automatic test_drain_pause();
		drain(SETTLE_CYCLES);
		set_sizes(20, WORDS);
		pacing_on = 1'b1;
		run_traffic(20);
		// hold the sender until every result is back
		drain(0);
		run_traffic(20);
	endtask

	initial begin : receiver
		rx_mode_t mode;
		int left, held;
		mode = RX_FLOW;
		left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				for (held = 0; held < LONG_HOLD_CYCLES; held++)
					@(posedge clk);
				long_hold_req = 1'b0;
			end
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				RX_FLOW:   out_stall <= 1'b0;
				RX_RANDOM: out_stall <= ($urandom_range(0, 1) == 1);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
				default:   out_stall <= (left % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (glyphs_due.size() == 0) begin
				$error("result with none pending: glyph_id %h status %0d", glyph_id, status);
				mismatches++;
			end else begin
				want = glyphs_due.pop_front();
				if (glyph_id !== want.glyph_id) begin
					$error("glyph_id: expected %h, got %h", want.glyph_id, glyph_id);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results pending", cycle_count, glyphs_due.size());
		$display("cmap4_char_to_glyph_lookup: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOOKUP;
		slot = '0;
		end_code = '0;
		start_code = '0;
		delta = '0;
		range_offset = '0;
		glyph_word = '0;
		char_code = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SEGMENT_COUNT;
		cfg_data = '0;
		seg_count_reg = 0;
		word_count_reg = 0;
		lookups_done = 0;
		loads_done = 0;
		ignored_done = 0;
		mismatches = 0;
		burst_left = 0;
		pacing_on = 1'b0;
		long_hold_req = 1'b0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_tables();
		test_size_extremes();
		test_output_hold();
		test_drain_pause();
		drain(SETTLE_CYCLES);

		$display("lookups checked %0d: mapped %0d, past end %0d, below start %0d, zero word %0d, out of range %0d",
			lookups_done, status_seen[STAT_MAPPED], status_seen[STAT_PAST_END],
			status_seen[STAT_BELOW_START], status_seen[STAT_GLYPH_ZERO],
			status_seen[STAT_OUT_OF_RANGE]);
		$display("table loads %0d, dropped items %0d, cycles %0d", loads_done, ignored_done,
			cycle_count);
		if (mismatches == 0)
			$display("cmap4_char_to_glyph_lookup: match");
		else
			$display("cmap4_char_to_glyph_lookup: mismatch");
		$finish;
	end

endmodule
